@@ hw/rtl/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the CAN fragment reassembler.
// ----------------------------------------------------------------------------
package cfr_pkg;

   localparam int SLOTS_DEFAULT     = 4;
   localparam int MSG_BYTES_DEFAULT = 256;
   localparam logic [7:0] TIMEOUT_RESET = 8'd5;
   localparam logic [8:0] SINGLE_INDEX  = 9'h1FF;

   typedef enum logic [1:0] {
      FRAG_SINGLE = 2'd0,
      FRAG_FIRST  = 2'd1,
      FRAG_MIDDLE = 2'd2,
      FRAG_LAST   = 2'd3
   } frag_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_WRITE,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_SINGLE
   } state_type;

   // compare request to the shared slot compare unit
   typedef struct packed {
      logic       busy;
      logic [3:0] serial;
      logic [6:0] source;
   } cmp_req_type;

endpackage

@@ hw/rtl/can_fragment_reassembler.sv @@
// ----------------------------------------------------------------------------
// can_fragment_reassembler
// Rebuilds segmented messages from extended CAN frames, streams words out.
// ----------------------------------------------------------------------------
// Sequence: an accepted fragment holds the input through the tag scan of
//   every slot, the decide state and its byte writes; a dropped frame through
//   scan and decide, a tick through the scan, a single frame through scan,
//   decide and its output handshake. A last fragment then streams ceil(size/8)
//   words (one if empty), each read byte by byte through the registered
//   byte-wide read port, then offered until rsp_tready. One request at a time.
// Reset (synchronous) frees all slots and loads timeout 5; byte RAM uncleared.
// ----------------------------------------------------------------------------
module can_fragment_reassembler #(
   parameter int SLOTS     = cfr_pkg::SLOTS_DEFAULT,
   parameter int MSG_BYTES = cfr_pkg::MSG_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [28:0] frame id, [32:29] frame length, [96:33] frame data, [103:97] zero
   input  logic [103:0] req_tdata,
   // [0] cmd
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [6:0] sender id, [15:7] byte count, [79:16] data word
   output logic [79:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);

   localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BW  = $clog2(MSG_BYTES + 1);
   localparam int OW  = $clog2(MSG_BYTES);
   localparam int AW  = $clog2(SLOTS * MSG_BYTES);
   localparam int CW  = $clog2(SLOTS + 1);

   cfr_pkg::state_type state_ff, state_in;

   logic [7:0]  timeout_ff;
   logic        cmd_ff;
   logic [28:0] id_ff;
   logic [3:0]  len_ff;
   logic [63:0] data_ff;

   logic             busy_ff   [SLOTS];
   logic [3:0]       serial_ff [SLOTS];
   logic [6:0]       source_ff [SLOTS];
   logic [BW-1:0]    fill_ff   [SLOTS];
   logic [8:0]       lidx_ff   [SLOTS];
   logic [7:0]       age_ff    [SLOTS];

   logic [CW-1:0] scan_ff;
   logic          hit_found_ff, free_found_ff;
   logic [SW-1:0] hit_slot_ff, free_slot_ff, sel_ff;
   logic [3:0]    bcnt_ff;
   logic [BW-1:0] pos_ff;
   logic [BW-1:0] size_ff;
   logic [6:0]    osrc_ff;
   logic [63:0]   word_ff;
   logic          rdv_ff;

   logic [3:0] f_serial;
   logic [6:0] f_source;
   logic [8:0] f_idx;
   cfr_pkg::frag_kind_type f_type;
   assign f_serial = id_ff[3:0];
   assign f_idx    = id_ff[12:4];
   assign f_source = id_ff[19:13];
   assign f_type   = cfr_pkg::frag_kind_type'({id_ff[28], id_ff[20]});

   logic [SW-1:0] scan_idx;
   assign scan_idx = scan_ff[SW-1:0];

   cfr_pkg::cmp_req_type cmp_slot;
   logic cmp_hit, cmp_free;
   assign cmp_slot = '{busy: busy_ff[scan_idx], serial: serial_ff[scan_idx],
                       source: source_ff[scan_idx]};

   cfr_slot_cmp u_cmp (
      .slot   (cmp_slot),
      .serial (f_serial),
      .source (f_source),
      .hit    (cmp_hit),
      .free   (cmp_free)
   );

   // decide
   logic [BW:0] new_fill;
   logic        accept_frag, is_last;
   always_comb begin
      new_fill    = {1'b0, fill_ff[hit_slot_ff]} + {{(BW-3){1'b0}}, len_ff};
      accept_frag = 1'b0;
      is_last     = (f_type == cfr_pkg::FRAG_LAST);
      unique case (f_type) inside
         cfr_pkg::FRAG_FIRST:
            accept_frag = (f_idx == 9'd0) && (hit_found_ff || free_found_ff);
         cfr_pkg::FRAG_MIDDLE, cfr_pkg::FRAG_LAST:
            // index compared one bit wider so 511 does not wrap to 0
            accept_frag = hit_found_ff
                          && ({1'b0, f_idx} == {1'b0, lidx_ff[hit_slot_ff]} + 10'd1)
                          && (new_fill <= (BW+1)'(MSG_BYTES));
         default: accept_frag = 1'b0;
      endcase
   end

   // byte RAM
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;
   logic [OW-1:0] wr_off;
   assign wr_off    = OW'(pos_ff + BW'(bcnt_ff));
   assign ram_we    = (state_ff == cfr_pkg::ST_WRITE) && (bcnt_ff < len_ff);
   assign ram_waddr = AW'(sel_ff) * AW'(MSG_BYTES) + AW'(wr_off);
   assign ram_wdata = data_ff[{bcnt_ff[2:0], 3'b000} +: 8];
   assign ram_raddr = AW'(sel_ff) * AW'(MSG_BYTES) + AW'(OW'(pos_ff));

   cfr_ram #(.WIDTH(8), .DEPTH(SLOTS * MSG_BYTES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic word_done, last_word;
   assign word_done = rdv_ff && (bcnt_ff == 4'd7);
   assign last_word = (BW'(pos_ff + BW'(1)) >= size_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfr_pkg::ST_IDLE:
            if (req_tvalid) state_in = cfr_pkg::ST_SEARCH;
         cfr_pkg::ST_SEARCH:
            if (scan_ff == CW'(SLOTS - 1)) begin
               if (cmd_ff) state_in = cfr_pkg::ST_IDLE;
               else        state_in = cfr_pkg::ST_DECIDE;
            end
         cfr_pkg::ST_DECIDE:
            if (len_ff > 4'd8) state_in = cfr_pkg::ST_IDLE;
            else if (f_type == cfr_pkg::FRAG_SINGLE)
               state_in = (f_idx == cfr_pkg::SINGLE_INDEX) ? cfr_pkg::ST_SINGLE
                                                           : cfr_pkg::ST_IDLE;
            else if (accept_frag) state_in = cfr_pkg::ST_WRITE;
            else state_in = cfr_pkg::ST_IDLE;
         cfr_pkg::ST_WRITE:
            if (bcnt_ff >= len_ff)
               state_in = is_last ? cfr_pkg::ST_EMIT_RD : cfr_pkg::ST_IDLE;
         cfr_pkg::ST_EMIT_RD:
            if (word_done) state_in = cfr_pkg::ST_EMIT_OUT;
         cfr_pkg::ST_EMIT_OUT:
            if (rsp_tready)
               state_in = rsp_tlast ? cfr_pkg::ST_IDLE : cfr_pkg::ST_EMIT_RD;
         cfr_pkg::ST_SINGLE:
            if (rsp_tready) state_in = cfr_pkg::ST_IDLE;
         default: state_in = cfr_pkg::ST_IDLE;
      endcase
   end

   // outputs
   logic [63:0] single_word;
   always_comb begin
      single_word = data_ff;
      for (int k = 0; k < 8; k++)
         if (4'(k) >= len_ff) single_word[k*8 +: 8] = 8'h00;
      req_tready = (state_ff == cfr_pkg::ST_IDLE) && !reset;
      rsp_tvalid = 1'b0;
      rsp_tdata  = '0;
      rsp_tlast  = 1'b0;
      unique case (state_ff)
         cfr_pkg::ST_SINGLE: begin
            rsp_tvalid = 1'b1;
            rsp_tdata  = {single_word, 5'd0, len_ff, f_source};
            rsp_tlast  = 1'b1;
         end
         cfr_pkg::ST_EMIT_OUT: begin
            rsp_tvalid = 1'b1;
            rsp_tdata  = {word_ff, 9'(size_ff), osrc_ff};
            rsp_tlast  = last_word;
         end
         default: ;
      endcase
   end

   // datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= cfr_pkg::ST_IDLE;
         timeout_ff <= cfr_pkg::TIMEOUT_RESET;
         for (int i = 0; i < SLOTS; i++) begin
            busy_ff[i]   <= 1'b0;
            serial_ff[i] <= '0;
            source_ff[i] <= '0;
            fill_ff[i]   <= '0;
            lidx_ff[i]   <= '0;
            age_ff[i]    <= '0;
         end
         rdv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) timeout_ff <= csr_wr_data;
         unique case (state_ff)
            cfr_pkg::ST_IDLE:
               if (req_tvalid) begin
                  cmd_ff        <= req_tuser;
                  id_ff         <= req_tdata[28:0];
                  len_ff        <= req_tdata[32:29];
                  data_ff       <= req_tdata[96:33];
                  scan_ff       <= '0;
                  hit_found_ff  <= 1'b0;
                  free_found_ff <= 1'b0;
                  hit_slot_ff   <= '0;
                  free_slot_ff  <= '0;
               end
            cfr_pkg::ST_SEARCH: begin
               scan_ff <= scan_ff + CW'(1);
               if (cmd_ff) begin
                  if (busy_ff[scan_idx]) begin
                     age_ff[scan_idx] <= age_ff[scan_idx] - 8'd1;
                     if (age_ff[scan_idx] == 8'd1) busy_ff[scan_idx] <= 1'b0;
                  end
               end else begin
                  if (cmp_hit && !hit_found_ff) begin
                     hit_found_ff <= 1'b1;
                     hit_slot_ff  <= scan_idx;
                  end
                  if (cmp_free && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_slot_ff  <= scan_idx;
                  end
               end
            end
            cfr_pkg::ST_DECIDE: begin
               bcnt_ff <= '0;
               osrc_ff <= f_source;
               if (f_type == cfr_pkg::FRAG_FIRST) begin
                  sel_ff <= hit_found_ff ? hit_slot_ff : free_slot_ff;
                  pos_ff <= '0;
               end else begin
                  sel_ff  <= hit_slot_ff;
                  pos_ff  <= fill_ff[hit_slot_ff];
                  size_ff <= BW'(new_fill);
               end
               if (len_ff <= 4'd8 && accept_frag) begin
                  if (f_type == cfr_pkg::FRAG_FIRST) begin
                     if (hit_found_ff) begin
                        fill_ff[hit_slot_ff] <= BW'(len_ff);
                        lidx_ff[hit_slot_ff] <= '0;
                        age_ff[hit_slot_ff]  <= timeout_ff;
                     end else begin
                        busy_ff[free_slot_ff]   <= 1'b1;
                        serial_ff[free_slot_ff] <= f_serial;
                        source_ff[free_slot_ff] <= f_source;
                        fill_ff[free_slot_ff]   <= BW'(len_ff);
                        lidx_ff[free_slot_ff]   <= '0;
                        age_ff[free_slot_ff]    <= timeout_ff;
                     end
                  end else begin
                     fill_ff[hit_slot_ff] <= BW'(new_fill);
                     lidx_ff[hit_slot_ff] <= f_idx;
                     if (is_last) busy_ff[hit_slot_ff] <= 1'b0;
                  end
               end
            end
            cfr_pkg::ST_WRITE: begin
               if (bcnt_ff < len_ff) bcnt_ff <= bcnt_ff + 4'd1;
               else begin
                  pos_ff  <= '0;
                  bcnt_ff <= '0;
                  word_ff <= '0;
               end
            end
            cfr_pkg::ST_EMIT_RD: begin
               // byte address pos_ff issued; its data returns in the next cycle, while rdv_ff is set
               rdv_ff <= !rdv_ff;
               if (rdv_ff) begin
                  if (pos_ff < size_ff) word_ff[{bcnt_ff[2:0], 3'b000} +: 8] <= ram_rdata;
                  if (bcnt_ff != 4'd7) begin
                     bcnt_ff <= bcnt_ff + 4'd1;
                     pos_ff  <= pos_ff + BW'(1);
                  end
               end
            end
            cfr_pkg::ST_EMIT_OUT:
               if (rsp_tready) begin
                  bcnt_ff <= '0;
                  word_ff <= '0;
                  pos_ff  <= pos_ff + BW'(1);
               end
            default: ;
         endcase
      end
   end

   // word_done holds only the cycle the last byte lands
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != cfr_pkg::ST_IDLE) |-> !req_tready)
      else $error("ready while busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (state_ff == cfr_pkg::ST_SINGLE || state_ff == cfr_pkg::ST_EMIT_OUT))
      else $error("response outside emit");
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == cfr_pkg::ST_WRITE && len_ff <= 4'd8))
      else $error("bad byte write");

endmodule

@@ hw/rtl/cfr_ram.sv @@
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/cfr_slot_cmp.sv @@
// ----------------------------------------------------------------------------
// cfr_slot_cmp
// Shared compare unit: tests one slot's tag against the request per cycle.
// ----------------------------------------------------------------------------
module cfr_slot_cmp (
   input  cfr_pkg::cmp_req_type slot,
   input  logic [3:0]           serial,
   input  logic [6:0]           source,
   output logic                 hit,
   output logic                 free
);

   assign hit  = slot.busy && (slot.serial == serial) && (slot.source == source);
   assign free = !slot.busy;

endmodule
